>>> hdl/rfft_pkg.sv
package rfft_pkg;

	localparam int MAX_LOG2_POINTS = 6;
	localparam int SAMPLE_BITS     = 16;
	localparam int INTERNAL_BITS   = 24;
	localparam int TWIDDLE_BITS    = 18;

	localparam int DEPTH   = 1 << MAX_LOG2_POINTS;
	localparam int HALF    = DEPTH / 2;
	localparam int ADDR_W  = MAX_LOG2_POINTS;
	localparam int TW_W    = MAX_LOG2_POINTS - 1;
	localparam int L_W     = 3;
	localparam int TW_FRAC = TWIDDLE_BITS - 2;
	localparam int PROD_W  = INTERNAL_BITS + TWIDDLE_BITS;
	localparam int ACC_W   = PROD_W + 1;
	localparam int T_W     = ACC_W - TW_FRAC;
	localparam int SUM_W   = T_W + 1;

	localparam int CFG_POINTS_LOG2 = 0;
	localparam int CFG_INVERSE     = 1;

	localparam longint TWO_PI_Q30 = 64'd6746518852;
	localparam longint ONE_Q30    = 64'd1 << 30;

	typedef logic signed [INTERNAL_BITS-1:0] data_t;
	typedef logic signed [TWIDDLE_BITS-1:0]  twv_t;

	typedef struct packed {
		twv_t c;
		twv_t s;
	} tw_t;

	typedef tw_t [HALF-1:0] tw_rom_t;

	typedef enum logic [3:0] {
		P_IDLE, P_LOAD, P_M0, P_M1, P_M2, P_M3, P_T, P_WA, P_WB
	} phase_t;

	typedef struct packed {
		phase_t            phase;
		logic              we;
		logic [ADDR_W-1:0] addr_a;
		logic [ADDR_W-1:0] addr_b;
		logic [TW_W-1:0]   tw_idx;
		logic              inverse;
	} core_ctrl_t;

	function automatic longint angle_f(longint num, int sh);
		return (TWO_PI_Q30 * num + (longint'(1) << (sh - 1))) >> sh;
	endfunction

	function automatic longint udiv_f(longint num, longint den);
		longint q;
		longint r;
		q = 0;
		r = 0;
		for (int i = 62; i >= 0; i--) begin
			r = (r << 1) | ((num >> i) & longint'(1));
			if (r >= den) begin
				r = r - den;
				q = q | (longint'(1) << i);
			end
		end
		return q;
	endfunction

	function automatic longint taylor_f(longint x, bit want_sin);
		longint x2;
		longint sum;
		longint term;
		longint d;
		x2   = (x * x) >> 30;
		term = want_sin ? x : ONE_Q30;
		sum  = term;
		for (int n = 1; n <= 7; n++) begin
			d    = want_sin ? longint'((2 * n) * (2 * n + 1)) : longint'((2 * n - 1) * (2 * n));
			term = udiv_f((term * x2) >> 30, d);
			sum  = ((n & 1) == 1) ? sum - term : sum + term;
		end
		if (sum < 0)
			sum = 0;
		if (sum > ONE_Q30)
			sum = ONE_Q30;
		return sum;
	endfunction

	function automatic longint to_tw_f(longint q30);
		longint v;
		v = (q30 + (longint'(1) << (29 - TW_FRAC))) >> (30 - TW_FRAC);
		if (v > (longint'(1) << TW_FRAC))
			v = longint'(1) << TW_FRAC;
		return v;
	endfunction

	function automatic tw_t quad_f(longint num, int sh);
		tw_t    r;
		longint x;
		if (8 * num <= (longint'(1) << sh)) begin
			x   = angle_f(num, sh);
			r.c = TWIDDLE_BITS'(to_tw_f(taylor_f(x, 1'b0)));
			r.s = TWIDDLE_BITS'(to_tw_f(taylor_f(x, 1'b1)));
		end else begin
			x   = angle_f((longint'(1) << sh) - 4 * num, sh + 2);
			r.c = TWIDDLE_BITS'(to_tw_f(taylor_f(x, 1'b1)));
			r.s = TWIDDLE_BITS'(to_tw_f(taylor_f(x, 1'b0)));
		end
		return r;
	endfunction

	function automatic tw_rom_t tw_rom_f();
		tw_rom_t rom;
		tw_t     q;
		for (int k = 0; k < HALF; k++) begin
			if (4 * k <= DEPTH) begin
				rom[k] = quad_f(longint'(k), MAX_LOG2_POINTS);
			end else begin
				q        = quad_f(longint'(4 * k - DEPTH), MAX_LOG2_POINTS + 2);
				rom[k].c = -q.s;
				rom[k].s = q.c;
			end
		end
		return rom;
	endfunction

	localparam tw_rom_t TW_ROM = tw_rom_f();

	function automatic data_t sat_f(logic signed [SUM_W-1:0] v);
		logic signed [SUM_W-1:0] hi;
		logic signed [SUM_W-1:0] lo;
		hi = SUM_W'((longint'(1) << (INTERNAL_BITS - 1)) - 1);
		lo = -hi - SUM_W'(1);
		if (v > hi)
			return hi[INTERNAL_BITS-1:0];
		if (v < lo)
			return lo[INTERNAL_BITS-1:0];
		return v[INTERNAL_BITS-1:0];
	endfunction

endpackage

>>> hdl/rfft_core.sv
module rfft_core (
	input  logic                clk,
	input  rfft_pkg::core_ctrl_t ctrl,
	input  rfft_pkg::data_t     ld_re,
	input  rfft_pkg::data_t     ld_im,
	output rfft_pkg::data_t     rd_re,
	output rfft_pkg::data_t     rd_im
);
	import rfft_pkg::*;

	data_t mem_re [DEPTH];
	data_t mem_im [DEPTH];

	data_t a_re_q, a_im_q, b_re_q, b_im_q;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [ACC_W-1:0]  acc_r_q, acc_i_q;
	logic signed [T_W-1:0]    tr_q, ti_q;

	tw_t  tw;
	twv_t wr, wi, mul_w;
	data_t mul_b;
	logic signed [ACC_W-1:0] rnd;
	logic signed [ACC_W-1:0] sum_r, sum_i;
	logic signed [SUM_W-1:0] ar_x, ai_x, tr_x, ti_x;

	assign tw  = TW_ROM[ctrl.tw_idx];
	assign wr  = tw.c;
	assign wi  = ctrl.inverse ? tw.s : -tw.s;
	assign rnd = ACC_W'(1) <<< (TW_FRAC - 1);

	always_comb begin
		case (ctrl.phase)
			P_M0:    begin mul_w = wr; mul_b = b_re_q; end
			P_M1:    begin mul_w = wi; mul_b = b_im_q; end
			P_M2:    begin mul_w = wr; mul_b = b_im_q; end
			P_M3:    begin mul_w = wi; mul_b = b_re_q; end
			default: begin mul_w = wr; mul_b = b_re_q; end
		endcase
	end

	assign sum_r = acc_r_q + rnd;
	assign sum_i = acc_i_q + ACC_W'(prod_q) + rnd;
	assign ar_x  = SUM_W'(a_re_q);
	assign ai_x  = SUM_W'(a_im_q);
	assign tr_x  = SUM_W'(tr_q);
	assign ti_x  = SUM_W'(ti_q);

	always_ff @(posedge clk) begin
		a_re_q <= mem_re[ctrl.addr_a];
		a_im_q <= mem_im[ctrl.addr_a];
		b_re_q <= mem_re[ctrl.addr_b];
		b_im_q <= mem_im[ctrl.addr_b];
		case (ctrl.phase)
			P_LOAD: begin
				if (ctrl.we) begin
					mem_re[ctrl.addr_a] <= ld_re;
					mem_im[ctrl.addr_a] <= ld_im;
				end
			end
			P_WA: begin
				mem_re[ctrl.addr_a] <= sat_f(ar_x + tr_x);
				mem_im[ctrl.addr_a] <= sat_f(ai_x + ti_x);
			end
			P_WB: begin
				mem_re[ctrl.addr_b] <= sat_f(ar_x - tr_x);
				mem_im[ctrl.addr_b] <= sat_f(ai_x - ti_x);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		case (ctrl.phase)
			P_M0: prod_q <= mul_w * mul_b;
			P_M1: begin
				acc_r_q <= ACC_W'(prod_q);
				prod_q  <= mul_w * mul_b;
			end
			P_M2: begin
				acc_r_q <= acc_r_q - ACC_W'(prod_q);
				prod_q  <= mul_w * mul_b;
			end
			P_M3: begin
				acc_i_q <= ACC_W'(prod_q);
				prod_q  <= mul_w * mul_b;
			end
			P_T: begin
				tr_q <= T_W'(sum_r >>> TW_FRAC);
				ti_q <= T_W'(sum_i >>> TW_FRAC);
			end
			default: ;
		endcase
	end

	assign rd_re = a_re_q;
	assign rd_im = a_im_q;

endmodule

>>> hdl/radix2_complex_fft_unit.sv
// channel   | signals                                  | dir
// sample    | sample_valid sample_stall sample_real/imag | in
// bin       | bin_valid bin_stall bin_real/imag/index last_bin | out
// cfg       | cfg_valid cfg_ready cfg_index cfg_data     | in
// Loading takes one cycle per sample; the last sample starts the transform.
// One shared butterfly (one multiplier) runs N/2*log2N butterflies, each through states
// RD, M0-M3, T, WA and WB; then each bin passes ORD, OLD and OHOLD, held by bin_stall.
// sample_stall is high from the last sample until the last bin is taken.
// arst_n clears control, the sample count and config; the store needs no clearing.
module radix2_complex_fft_unit (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    sample_valid,
	output logic                                    sample_stall,
	input  logic signed [rfft_pkg::SAMPLE_BITS-1:0] sample_real,
	input  logic signed [rfft_pkg::SAMPLE_BITS-1:0] sample_imag,
	output logic                                    bin_valid,
	input  logic                                    bin_stall,
	output rfft_pkg::data_t                         bin_real,
	output rfft_pkg::data_t                         bin_imag,
	output logic [rfft_pkg::ADDR_W-1:0]             bin_index,
	output logic                                    last_bin,
	input  logic                                    cfg_valid,
	output logic                                    cfg_ready,
	input  logic                                    cfg_index,
	input  logic [rfft_pkg::L_W-1:0]                cfg_data
);
	import rfft_pkg::*;

	typedef enum logic [3:0] {
		ST_LOAD, ST_RD, ST_M0, ST_M1, ST_M2, ST_M3, ST_T, ST_WA, ST_WB,
		ST_ORD, ST_OLD, ST_OHOLD
	} state_t;

	state_t state_q;
	logic [L_W-1:0]    points_log2_q;
	logic              inverse_q;
	logic [ADDR_W-1:0] cnt_q;
	logic [L_W-1:0]    stage_q;
	logic [TW_W-1:0]   bf_q;

	logic [L_W-1:0]    l_eff;
	logic [ADDR_W-1:0] n_last;
	logic [TW_W-1:0]   bf_last;
	logic [ADDR_W-1:0] rev, bf6, jmask, bf_a, bf_b, tw_full;
	core_ctrl_t        ctrl;
	data_t             ld_re, ld_im, rd_re, rd_im;
	logic              s_acc;

	always_comb begin
		if (points_log2_q == '0)
			l_eff = L_W'(1);
		else if (points_log2_q > L_W'(MAX_LOG2_POINTS))
			l_eff = L_W'(MAX_LOG2_POINTS);
		else
			l_eff = points_log2_q;
	end

	assign n_last  = ADDR_W'(((ADDR_W+1)'(1) << l_eff) - (ADDR_W+1)'(1));
	assign bf_last = TW_W'(n_last >> 1);

	always_comb begin
		for (int i = 0; i < ADDR_W; i++)
			rev[i] = cnt_q[ADDR_W-1-i];
	end

	assign bf6     = ADDR_W'(bf_q);
	assign jmask   = (ADDR_W'(1) << stage_q) - ADDR_W'(1);
	assign bf_a    = ((bf6 >> stage_q) << (stage_q + L_W'(1))) | (bf6 & jmask);
	assign bf_b    = bf_a | (ADDR_W'(1) << stage_q);
	assign tw_full = (bf6 & jmask) << (L_W'(TW_W) - stage_q);

	assign s_acc        = sample_valid && !sample_stall;
	assign sample_stall = (state_q != ST_LOAD);
	assign cfg_ready    = 1'b1;

	assign ld_re = data_t'(sample_real);
	assign ld_im = data_t'(sample_imag);

	always_comb begin
		ctrl.we      = s_acc;
		ctrl.inverse = inverse_q;
		ctrl.tw_idx  = tw_full[TW_W-1:0];
		ctrl.addr_b  = bf_b;
		case (state_q)
			ST_LOAD: ctrl.addr_a = rev >> (L_W'(MAX_LOG2_POINTS) - l_eff);
			ST_ORD, ST_OLD, ST_OHOLD: ctrl.addr_a = cnt_q;
			default: ctrl.addr_a = bf_a;
		endcase
		case (state_q)
			ST_LOAD: ctrl.phase = P_LOAD;
			ST_M0:   ctrl.phase = P_M0;
			ST_M1:   ctrl.phase = P_M1;
			ST_M2:   ctrl.phase = P_M2;
			ST_M3:   ctrl.phase = P_M3;
			ST_T:    ctrl.phase = P_T;
			ST_WA:   ctrl.phase = P_WA;
			ST_WB:   ctrl.phase = P_WB;
			default: ctrl.phase = P_IDLE;
		endcase
	end

	rfft_core u_core (
		.clk   (clk),
		.ctrl  (ctrl),
		.ld_re (ld_re),
		.ld_im (ld_im),
		.rd_re (rd_re),
		.rd_im (rd_im)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_LOAD;
			points_log2_q <= L_W'(MAX_LOG2_POINTS);
			inverse_q     <= 1'b0;
			cnt_q         <= '0;
			stage_q       <= '0;
			bf_q          <= '0;
			bin_valid     <= 1'b0;
			bin_real      <= '0;
			bin_imag      <= '0;
			bin_index     <= '0;
			last_bin      <= 1'b0;
		end else begin
			case (state_q)
				ST_LOAD: begin
					if (s_acc) begin
						if (cnt_q == n_last) begin
							cnt_q   <= '0;
							stage_q <= '0;
							bf_q    <= '0;
							state_q <= ST_RD;
						end else begin
							cnt_q <= cnt_q + ADDR_W'(1);
						end
					end
				end
				ST_RD: state_q <= ST_M0;
				ST_M0: state_q <= ST_M1;
				ST_M1: state_q <= ST_M2;
				ST_M2: state_q <= ST_M3;
				ST_M3: state_q <= ST_T;
				ST_T:  state_q <= ST_WA;
				ST_WA: state_q <= ST_WB;
				ST_WB: begin
					if (bf_q == bf_last) begin
						bf_q <= '0;
						if (stage_q == l_eff - L_W'(1)) begin
							cnt_q   <= '0;
							state_q <= ST_ORD;
						end else begin
							stage_q <= stage_q + L_W'(1);
							state_q <= ST_RD;
						end
					end else begin
						bf_q    <= bf_q + TW_W'(1);
						state_q <= ST_RD;
					end
				end
				ST_ORD: state_q <= ST_OLD;
				ST_OLD: begin
					bin_real  <= inverse_q ? (rd_re >>> l_eff) : rd_re;
					bin_imag  <= inverse_q ? (rd_im >>> l_eff) : rd_im;
					bin_index <= cnt_q;
					last_bin  <= (cnt_q == n_last);
					bin_valid <= 1'b1;
					state_q   <= ST_OHOLD;
				end
				ST_OHOLD: begin
					if (!bin_stall) begin
						bin_valid <= 1'b0;
						if (cnt_q == n_last) begin
							cnt_q   <= '0;
							state_q <= ST_LOAD;
						end else begin
							cnt_q   <= cnt_q + ADDR_W'(1);
							state_q <= ST_ORD;
						end
					end
				end
				default: state_q <= ST_LOAD;
			endcase
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == 1'(CFG_POINTS_LOG2)) begin
					points_log2_q <= cfg_data;
					cnt_q         <= '0;
				end else if (cfg_index == 1'(CFG_INVERSE)) begin
					inverse_q <= cfg_data[0];
				end
			end
		end
	end

endmodule

>>> tb/tb_radix2_complex_fft_unit.sv
module tb_radix2_complex_fft_unit;
	import rfft_pkg::*;

	typedef struct {
		data_t             re;
		data_t             im;
		logic [ADDR_W-1:0] idx;
		logic              last;
	} bin_t;

	logic                          clk;
	logic                          arst_n;
	logic                          sample_valid;
	logic                          sample_stall;
	logic signed [SAMPLE_BITS-1:0] sample_real;
	logic signed [SAMPLE_BITS-1:0] sample_imag;
	logic                          bin_valid;
	logic                          bin_stall;
	data_t                         bin_real;
	data_t                         bin_imag;
	logic [ADDR_W-1:0]             bin_index;
	logic                          last_bin;
	logic                          cfg_valid;
	logic                          cfg_ready;
	logic                          cfg_index;
	logic [L_W-1:0]                cfg_data;

	radix2_complex_fft_unit u_top (
		.clk(clk), .arst_n(arst_n),
		.sample_valid(sample_valid), .sample_stall(sample_stall),
		.sample_real(sample_real), .sample_imag(sample_imag),
		.bin_valid(bin_valid), .bin_stall(bin_stall),
		.bin_real(bin_real), .bin_imag(bin_imag),
		.bin_index(bin_index), .last_bin(last_bin),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	bin_t   bins_due[$];
	longint pend_re[DEPTH];
	longint pend_im[DEPTH];
	int     len_reg;
	bit     inv_reg;
	int     fill;
	int     idle_pct;
	int     stall_pct;
	int     errors;
	int     n_samples;
	int     n_bins;
	int     n_ffts;
	longint cycles;

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 64'd3000000) begin
			$display("timeout after %0d cycles", cycles);
			$display("Regression FAIL");
			$finish;
		end
	end

	always @(posedge clk)
		bin_stall <= ($urandom_range(0, 99) < stall_pct);

	function automatic longint angle_q30(longint num, int sh);
		return (64'd6746518852 * num + (64'd1 << (sh - 1))) >> sh;
	endfunction

	function automatic longint series(longint x, bit want_sin);
		longint x2, sum, term, d;
		x2   = (x * x) >> 30;
		term = want_sin ? x : (64'd1 << 30);
		sum  = term;
		for (int n = 1; n <= 7; n++) begin
			d    = want_sin ? (2 * n) * (2 * n + 1) : (2 * n - 1) * (2 * n);
			term = ((term * x2) >> 30) / d;
			sum  = (n % 2) ? sum - term : sum + term;
		end
		if (sum < 0)
			sum = 0;
		if (sum > (64'd1 << 30))
			sum = 64'd1 << 30;
		return sum;
	endfunction

	function automatic longint q30_to_coef(longint v);
		longint r;
		r = (v + (64'd1 << (29 - TW_FRAC))) >> (30 - TW_FRAC);
		return (r > (64'd1 << TW_FRAC)) ? (64'd1 << TW_FRAC) : r;
	endfunction

	task automatic quarter_cs(input longint num, input int sh, output longint c,
			output longint s);
		longint x;
		if (8 * num <= (64'd1 << sh)) begin
			x = angle_q30(num, sh);
			c = q30_to_coef(series(x, 1'b0));
			s = q30_to_coef(series(x, 1'b1));
		end else begin
			x = angle_q30((64'd1 << sh) - 4 * num, sh + 2);
			c = q30_to_coef(series(x, 1'b1));
			s = q30_to_coef(series(x, 1'b0));
		end
	endtask

	task automatic rotation(input longint k, input int l, output longint c,
			output longint s);
		longint c2, s2;
		if (4 * k <= (64'd1 << l)) begin
			quarter_cs(k, l, c, s);
		end else begin
			quarter_cs(4 * k - (64'd1 << l), l + 2, c2, s2);
			c = -s2;
			s = c2;
		end
	endtask

	function automatic longint clip24(longint v);
		longint hi;
		hi = (64'd1 << (INTERNAL_BITS - 1)) - 1;
		return (v > hi) ? hi : ((v < -hi - 1) ? -hi - 1 : v);
	endfunction

	function automatic int eff_len();
		if (len_reg < 1)
			return 1;
		if (len_reg > MAX_LOG2_POINTS)
			return MAX_LOG2_POINTS;
		return len_reg;
	endfunction

	task automatic compute_spectrum();
		int     l, n, r, a, b, half;
		longint t, wr, wi, tr, ti, ar, ai, br, bi;
		bin_t   e;
		l = eff_len();
		n = 1 << l;
		for (int i = 0; i < n; i++) begin
			r = 0;
			for (int q = 0; q < l; q++)
				r |= ((i >> q) & 1) << (l - 1 - q);
			if (r > i) begin
				t = pend_re[i]; pend_re[i] = pend_re[r]; pend_re[r] = t;
				t = pend_im[i]; pend_im[i] = pend_im[r]; pend_im[r] = t;
			end
		end
		for (int s = 0; s < l; s++) begin
			half = 1 << s;
			for (int j = 0; j < half; j++) begin
				rotation(j, s + 1, wr, wi);
				if (!inv_reg)
					wi = -wi;
				for (int k = 0; k < n; k += 2 * half) begin
					a  = k + j;
					b  = a + half;
					br = pend_re[b];
					bi = pend_im[b];
					tr = (wr * br - wi * bi + (longint'(1) << (TW_FRAC - 1))) >>> TW_FRAC;
					ti = (wr * bi + wi * br + (longint'(1) << (TW_FRAC - 1))) >>> TW_FRAC;
					ar = pend_re[a];
					ai = pend_im[a];
					pend_re[a] = clip24(ar + tr);
					pend_im[a] = clip24(ai + ti);
					pend_re[b] = clip24(ar - tr);
					pend_im[b] = clip24(ai - ti);
				end
			end
		end
		for (int i = 0; i < n; i++) begin
			e.re   = INTERNAL_BITS'(inv_reg ? (pend_re[i] >>> l) : pend_re[i]);
			e.im   = INTERNAL_BITS'(inv_reg ? (pend_im[i] >>> l) : pend_im[i]);
			e.idx  = ADDR_W'(i);
			e.last = (i == n - 1);
			bins_due = {bins_due, e};
		end
		n_ffts++;
	endtask

	task automatic push_sample(input logic signed [SAMPLE_BITS-1:0] re,
			input logic signed [SAMPLE_BITS-1:0] im);
		while ($urandom_range(0, 99) < idle_pct) begin
			sample_valid <= 1'b0;
			@(posedge clk);
		end
		sample_valid <= 1'b1;
		sample_real  <= re;
		sample_imag  <= im;
		do @(posedge clk); while (sample_stall);
		n_samples++;
		pend_re[fill] = re;
		pend_im[fill] = im;
		fill++;
		if (fill >= (1 << eff_len())) begin
			fill = 0;
			compute_spectrum();
		end
	endtask

	task automatic settle();
		sample_valid <= 1'b0;
		while (bins_due.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_reg(input int idx, input int val);
		settle();
		cfg_valid <= 1'b1;
		cfg_index <= idx[0];
		cfg_data  <= L_W'(val);
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == CFG_POINTS_LOG2) begin
			len_reg = val;
			fill    = 0;
		end else begin
			inv_reg = val[0];
		end
	endtask

	function automatic logic signed [SAMPLE_BITS-1:0] rand_word();
		case ($urandom_range(0, 3))
			0: return SAMPLE_BITS'($urandom_range(0, 65535));
			1: return SAMPLE_BITS'(int'($urandom_range(0, 512)) - 256);
			2: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
			default: return SAMPLE_BITS'($urandom);
		endcase
	endfunction

	task automatic send_frame();
		for (int i = 0; i < (1 << eff_len()); i++)
			push_sample(rand_word(), rand_word());
	endtask

	always @(posedge clk) begin
		bin_t e;
		if (arst_n && bin_valid && !bin_stall) begin
			n_bins++;
			if (bins_due.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected bin idx=%0d re=%0d im=%0d", bin_index,
						bin_real, bin_imag);
			end else begin
				e = bins_due.pop_front();
				if (e.re !== bin_real || e.im !== bin_imag || e.idx !== bin_index ||
						e.last !== last_bin) begin
					errors++;
					if (errors <= 10)
						$display("bin mismatch exp re=%0d im=%0d idx=%0d last=%0b %s",
							e.re, e.im, e.idx, e.last, "");
					if (errors <= 10)
						$display("             got re=%0d im=%0d idx=%0d last=%0b",
							bin_real, bin_imag, bin_index, last_bin);
				end
			end
		end
	end

	task automatic test_default_length();
		for (int i = 0; i < 64; i++)
			push_sample(SAMPLE_BITS'(i * 977), SAMPLE_BITS'(-i * 511));
	endtask

	task automatic test_extremes();
		write_reg(CFG_POINTS_LOG2, 1);
		write_reg(CFG_INVERSE, 0);
		push_sample(16'sh7fff, 16'sh7fff);
		push_sample(16'sh8000, 16'sh8000);
		push_sample(16'sh8000, 16'sh7fff);
		push_sample(16'sh7fff, 16'sh8000);
		write_reg(CFG_INVERSE, 1);
		push_sample(16'sh8000, 16'sh8000);
		push_sample(16'sh0001, 16'shffff);
	endtask

	task automatic test_length_clamp();
		write_reg(CFG_POINTS_LOG2, 0);
		write_reg(CFG_INVERSE, 0);
		push_sample(16'sh1234, 16'shedcb);
		push_sample(16'sh7fff, 16'sh0000);
		write_reg(CFG_POINTS_LOG2, 7);
		for (int i = 0; i < 64; i++)
			push_sample(16'sh7fff, 16'sh8000);
	endtask

	task automatic test_partial_load();
		write_reg(CFG_POINTS_LOG2, 3);
		push_sample(16'sh4000, 16'sh0100);
		push_sample(16'sh8000, 16'sh0200);
		push_sample(16'sh7fff, 16'sh0300);
		write_reg(CFG_POINTS_LOG2, 2);
		push_sample(16'sh0001, 16'sh0000);
		push_sample(16'sh0002, 16'sh0000);
		write_reg(CFG_INVERSE, 1);
		push_sample(16'sh0003, 16'shffff);
		push_sample(16'sh0004, 16'sh8000);
	endtask

	task automatic test_random_phase(input int src_idle, input int rcv_stall,
			input int budget);
		int sent;
		int l;
		idle_pct  = src_idle;
		stall_pct = rcv_stall;
		sent      = 0;
		while (sent < budget) begin
			l = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 7) : $urandom_range(1, 4);
			write_reg(CFG_POINTS_LOG2, l);
			write_reg(CFG_INVERSE, $urandom_range(0, 1));
			repeat ($urandom_range(1, 3)) begin
				send_frame();
				sent += 1 << eff_len();
			end
			if ($urandom_range(0, 4) == 0) begin
				repeat ($urandom_range(1, (1 << eff_len()) - 1 > 0 ?
						(1 << eff_len()) - 1 : 1))
					push_sample(rand_word(), rand_word());
				if ($urandom_range(0, 1))
					write_reg(CFG_INVERSE, $urandom_range(0, 1));
				send_frame();
				sent += 1 << eff_len();
			end
		end
		idle_pct  = 0;
		stall_pct = 0;
	endtask

	initial begin
		clk          = 1'b0;
		arst_n       = 1'b0;
		sample_valid = 1'b0;
		sample_real  = '0;
		sample_imag  = '0;
		bin_stall    = 1'b0;
		cfg_valid    = 1'b0;
		cfg_index    = 1'b0;
		cfg_data     = '0;
		cycles       = 0;
		errors       = 0;
		n_samples    = 0;
		n_bins       = 0;
		n_ffts       = 0;
		idle_pct     = 0;
		stall_pct    = 0;
		len_reg      = 6;
		inv_reg      = 1'b0;
		fill         = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_default_length();
		test_extremes();
		test_length_clamp();
		test_partial_load();
		test_random_phase(0, 0, 60);
		test_random_phase(83, 0, 60);
		test_random_phase(0, 83, 60);
		test_random_phase(15, 15, 60);
		settle();
		if (bins_due.size() != 0)
			errors++;
		$display("%0d samples sent, %0d transforms, %0d bins checked", n_samples, n_ffts,
			n_bins);
		$display("lengths 2..64 incl. clamped codes, both directions, idle and stall mixes");
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
